// ----- src/lbvs_pkg.sv -----
`default_nettype none

package lbvs_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_BONES_DEFAULT = 64;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Bone table layout: nine rotation words, then three translation words.
   localparam int WORDS_PER_BONE = 12;
   localparam int TRANS_BASE = 9;
   localparam int ADDR_CALC_W = 16;

   // Datapath widths.
   localparam int WORD_W = 32;
   localparam int NRM_W = 18;
   localparam int WEIGHT_W = 17;
   localparam int BONE_W = 6;
   localparam int WIDX_W = 4;
   localparam int MUL_W = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W = 64;
   localparam int SUM_W = 48;
   localparam int DVD_W = 64;
   localparam int DVS_W = 32;
   localparam int RAD_W = 64;
   localparam int ROOT_W = 32;

   // Stream layout.
   localparam int OP_W = 2;
   localparam int REQ_TDATA_W = 216;
   localparam int RSP_TDATA_W = 192;
   localparam int OFS_BONE = 0;
   localparam int OFS_WIDX = 6;
   localparam int OFS_WVAL = 10;
   localparam int OFS_POS = 42;
   localparam int OFS_NRM = 138;
   localparam int OFS_WEIGHT = 192;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 2'd0,
      OP_INFLUENCE = 2'd1,
      OP_UNSKINNED = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_X   = 2'd0,
      CSR_SCALE_Y   = 2'd1,
      CSR_SCALE_Z   = 2'd2,
      CSR_NORMALIZE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INF,
      ST_POS,
      ST_NQ,
      ST_NQ_WAIT,
      ST_SS,
      ST_SQRT,
      ST_ND,
      ST_ND_WAIT,
      ST_EMIT
   } state_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < 64'shFFFF_FFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Saturate a wide signed value to 48 bits.
   function automatic logic signed [SUM_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
      logic signed [SUM_W-1:0] r;
      if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
         r = 48'sh7FFF_FFFF_FFFF;
      end else if (x < 64'shFFFF_8000_0000_0000) begin
         r = 48'sh8000_0000_0000;
      end else begin
         r = x[SUM_W-1:0];
      end
      return r;
   endfunction

   // Magnitude of a signed 32-bit word.
   function automatic logic [32:0] abs33(input logic signed [31:0] x);
      logic signed [32:0] e;
      e = 33'(x);
      return x[31] ? 33'(-e) : 33'(e);
   endfunction

   // Apply a sign to a quotient magnitude and saturate to 32 bits.
   function automatic logic signed [31:0] sat_quot(input logic neg,
                                                   input logic [DVD_W-1:0] mag);
      logic signed [31:0] r;
      if (neg) begin
         if (mag >= 64'h0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
         end else begin
            r = -$signed(mag[31:0]);
         end
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
         end else begin
            r = $signed(mag[31:0]);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/linear_blend_vertex_skinning_top.sv -----
// Linear blend vertex skinner, one vertex at a time, Q16.16 fixed point.
// Input beats arrive on req_*: tuser carries the operation (load a bone word,
// one influence of a vertex, or an unskinned vertex), tlast marks the final
// influence of a vertex. Result beats leave on rsp_* with the skinned position
// and normal. Axis scales and the normalize flag are written on csr_*; the user
// must write them only while the block is idle, which the block itself does not
// enforce; csr_ready is always high. Bone words live in a single-port-read
// synchronous table; an in-range load beat is written into it while idle.
// Every influence runs each axis through one shared 33x33 multiplier, which
// reads the bone row from the table one word a cycle. After the last influence
// or an unskinned vertex the position is scaled; with normalization on, up to
// three bit-serial divisions, a square root and up to three more follow.
// Reset clears the sums, the result valid flag and the control state and sets
// the scales to 1.0 with normalization on; the bone table is not cleared and
// must be loaded before use. A finished result waits in an output register;
// the next input beat is taken while it waits, but a following result is
// held back until the receiver has taken the previous one.
`default_nettype none

module linear_blend_vertex_skinning_top #(
   parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEFAULT,
   parameter int FRAC_BITS = lbvs_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // bone_id, word_index, word_value, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
   // weight, zero pad
   input  wire logic [lbvs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op
   input  wire logic [lbvs_pkg::OP_W-1:0]           req_tuser,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
   output logic      [lbvs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lbvs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [31:0]                         csr_data
);

   localparam int TABLE_DEPTH = MAX_BONES * lbvs_pkg::WORDS_PER_BONE;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CAW = lbvs_pkg::ADDR_CALC_W;

   // Input fields.
   lbvs_pkg::op_type                  in_op;
   logic [lbvs_pkg::BONE_W-1:0]       in_bone;
   logic [lbvs_pkg::WIDX_W-1:0]       in_widx;
   logic [31:0]                       in_wval;
   logic signed [31:0]                in_pos [3];
   logic signed [lbvs_pkg::NRM_W-1:0] in_nrm [3];
   logic [lbvs_pkg::WEIGHT_W-1:0]     in_weight;

   assign in_op     = lbvs_pkg::op_type'(req_tuser);
   assign in_bone   = req_tdata[lbvs_pkg::OFS_BONE +: lbvs_pkg::BONE_W];
   assign in_widx   = req_tdata[lbvs_pkg::OFS_WIDX +: lbvs_pkg::WIDX_W];
   assign in_wval   = req_tdata[lbvs_pkg::OFS_WVAL +: 32];
   assign in_weight = req_tdata[lbvs_pkg::OFS_WEIGHT +: lbvs_pkg::WEIGHT_W];

   for (genvar k = 0; k < 3; k++) begin : g_fields
      assign in_pos[k] = $signed(req_tdata[lbvs_pkg::OFS_POS + 32*k +: 32]);
      assign in_nrm[k] = $signed(req_tdata[lbvs_pkg::OFS_NRM + lbvs_pkg::NRM_W*k +:
                                           lbvs_pkg::NRM_W]);
   end

   // Control and working registers.
   lbvs_pkg::state_type               state_ff, state_in;
   logic [3:0]                        st_ff, st_in;
   logic [1:0]                        ci_ff, ci_in;
   logic [lbvs_pkg::BONE_W-1:0]       bone_ff, bone_in;
   logic                              bone_ok_ff, bone_ok_in;
   logic                              last_ff, last_in;
   logic signed [31:0]                pos_ff [3], pos_in [3];
   logic signed [lbvs_pkg::NRM_W-1:0] nrm_ff [3], nrm_in [3];
   logic [lbvs_pkg::WEIGHT_W-1:0]     wt_ff, wt_in;
   logic signed [31:0]                r_ff [3], r_in [3];
   logic signed [lbvs_pkg::ACC_W-1:0] v_ff, v_in;
   logic signed [lbvs_pkg::ACC_W-1:0] m_ff, m_in;
   logic signed [lbvs_pkg::SUM_W-1:0] psum_ff [3], psum_in [3];
   logic signed [lbvs_pkg::SUM_W-1:0] nsum_ff [3], nsum_in [3];
   logic signed [31:0]                opos_ff [3], opos_in [3];
   logic signed [31:0]                q_ff [3], q_in [3];
   logic [lbvs_pkg::RAD_W-1:0]        ss_ff, ss_in;
   logic [lbvs_pkg::ROOT_W-1:0]       len_ff, len_in;
   logic                              div_neg_ff, div_neg_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lbvs_pkg::RSP_TDATA_W-1:0]  rsp_data_ff;
   logic                              rsp_load;

   // Configuration registers.
   logic signed [31:0]                scale_ff [3];
   logic                              norm_ff;

   // Shared multiplier.
   logic signed [lbvs_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [lbvs_pkg::PROD_W-1:0] prod_ff;
   logic signed [lbvs_pkg::ACC_W-1:0]  prod_sh;

   // Bone table ports.
   logic                              ram_we;
   logic [CAW-1:0]                    wr_addr_full;
   logic [CAW-1:0]                    rd_addr_full;
   logic [lbvs_pkg::WIDX_W-1:0]       rd_word;
   logic [lbvs_pkg::WIDX_W-1:0]       row_base;
   logic [31:0]                       ram_rdata;
   logic signed [31:0]                rword;

   // Divider and square root handshakes.
   logic                              div_start;
   logic [lbvs_pkg::DVD_W-1:0]        div_dividend;
   logic [lbvs_pkg::DVS_W-1:0]        div_divisor;
   logic                              div_done;
   logic [lbvs_pkg::DVD_W-1:0]        div_quot;
   logic                              sqrt_start;
   logic                              sqrt_done;
   logic [lbvs_pkg::ROOT_W-1:0]       sqrt_root;

   logic signed [31:0]                nq;
   logic signed [31:0]                cur_scale;
   logic signed [31:0]                cur_q;

   // Bone table write on a load beat with a bone and word in range.
   assign ram_we = req_tvalid && req_tready && (in_op == lbvs_pkg::OP_LOAD) &&
                   (int'(in_bone) < MAX_BONES) &&
                   (int'(in_widx) < lbvs_pkg::WORDS_PER_BONE);
   assign wr_addr_full = CAW'(in_bone) * CAW'(lbvs_pkg::WORDS_PER_BONE) + CAW'(in_widx);
   assign rd_addr_full = CAW'(bone_ff) * CAW'(lbvs_pkg::WORDS_PER_BONE) + CAW'(rd_word);

   lbvs_ram #(
      .WIDTH(32),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_addr_full[AW-1:0]),
      .wr_data(in_wval),
      .rd_addr(rd_addr_full[AW-1:0]),
      .rd_data(ram_rdata)
   );

   // A bone beyond the table reads as all zeros.
   assign rword = bone_ok_ff ? $signed(ram_rdata) : 32'sd0;

   lbvs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quot)
   );

   lbvs_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand(ss_ff),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // Registered product, then the Q-format shift.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end
   assign prod_sh = lbvs_pkg::ACC_W'(prod_ff >>> FRAC_BITS);

   assign row_base  = lbvs_pkg::WIDX_W'(ci_ff) * lbvs_pkg::WIDX_W'(3);
   assign nq        = lbvs_pkg::sat32(lbvs_pkg::ACC_W'(nsum_ff[ci_ff]));
   assign cur_scale = scale_ff[ci_ff];
   assign cur_q     = q_ff[ci_ff];

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      ci_in        = ci_ff;
      bone_in      = bone_ff;
      bone_ok_in   = bone_ok_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      nrm_in       = nrm_ff;
      wt_in        = wt_ff;
      r_in         = r_ff;
      v_in         = v_ff;
      m_in         = m_ff;
      psum_in      = psum_ff;
      nsum_in      = nsum_ff;
      opos_in      = opos_ff;
      q_in         = q_ff;
      ss_in        = ss_ff;
      len_in       = len_ff;
      div_neg_in   = div_neg_ff;
      req_tready   = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rd_word      = row_base;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      sqrt_start   = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         lbvs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               bone_in    = in_bone;
               bone_ok_in = int'(in_bone) < MAX_BONES;
               last_in    = req_tlast;
               pos_in     = in_pos;
               nrm_in     = in_nrm;
               wt_in      = in_weight;
               st_in      = '0;
               ci_in      = '0;
               case (in_op)
                  lbvs_pkg::OP_INFLUENCE: begin
                     state_in = lbvs_pkg::ST_INF;
                  end
                  lbvs_pkg::OP_UNSKINNED: begin
                     for (int k = 0; k < 3; k++) begin
                        psum_in[k] = lbvs_pkg::SUM_W'(in_pos[k]);
                        nsum_in[k] = lbvs_pkg::SUM_W'(in_nrm[k]);
                     end
                     state_in = lbvs_pkg::ST_POS;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One row of the bone: fetch four words, six products, two weighted adds.
         lbvs_pkg::ST_INF: begin
            st_in = st_ff + 1'b1;
            case (st_ff)
               4'd0: rd_word = row_base;
               4'd1: begin
                  rd_word = row_base + 1'b1;
                  r_in[0] = rword;
               end
               4'd2: begin
                  rd_word = row_base + 2'd2;
                  r_in[1] = rword;
               end
               4'd3: begin
                  rd_word = lbvs_pkg::WIDX_W'(lbvs_pkg::TRANS_BASE) +
                            lbvs_pkg::WIDX_W'(ci_ff);
                  r_in[2] = rword;
               end
               4'd4: begin
                  v_in  = lbvs_pkg::ACC_W'(rword);
                  m_in  = '0;
                  mul_a = lbvs_pkg::MUL_W'(r_ff[0]);
                  mul_b = lbvs_pkg::MUL_W'(pos_ff[0]);
               end
               4'd5: begin
                  v_in  = v_ff + prod_sh;
                  mul_a = lbvs_pkg::MUL_W'(r_ff[0]);
                  mul_b = lbvs_pkg::MUL_W'(nrm_ff[0]);
               end
               4'd6: begin
                  m_in  = m_ff + prod_sh;
                  mul_a = lbvs_pkg::MUL_W'(r_ff[1]);
                  mul_b = lbvs_pkg::MUL_W'(pos_ff[1]);
               end
               4'd7: begin
                  v_in  = v_ff + prod_sh;
                  mul_a = lbvs_pkg::MUL_W'(r_ff[1]);
                  mul_b = lbvs_pkg::MUL_W'(nrm_ff[1]);
               end
               4'd8: begin
                  m_in  = m_ff + prod_sh;
                  mul_a = lbvs_pkg::MUL_W'(r_ff[2]);
                  mul_b = lbvs_pkg::MUL_W'(pos_ff[2]);
               end
               4'd9: begin
                  v_in  = v_ff + prod_sh;
                  mul_a = lbvs_pkg::MUL_W'(r_ff[2]);
                  mul_b = lbvs_pkg::MUL_W'(nrm_ff[2]);
               end
               4'd10: begin
                  m_in = m_ff + prod_sh;
               end
               4'd11: begin
                  mul_a = lbvs_pkg::MUL_W'(lbvs_pkg::sat32(v_ff));
                  mul_b = $signed({{(lbvs_pkg::MUL_W - lbvs_pkg::WEIGHT_W){1'b0}}, wt_ff});
               end
               4'd12: begin
                  psum_in[ci_ff] = lbvs_pkg::sat48(lbvs_pkg::ACC_W'(psum_ff[ci_ff]) + prod_sh);
                  mul_a = lbvs_pkg::MUL_W'(lbvs_pkg::sat32(m_ff));
                  mul_b = $signed({{(lbvs_pkg::MUL_W - lbvs_pkg::WEIGHT_W){1'b0}}, wt_ff});
               end
               default: begin
                  nsum_in[ci_ff] = lbvs_pkg::sat48(lbvs_pkg::ACC_W'(nsum_ff[ci_ff]) + prod_sh);
                  st_in = '0;
                  if (ci_ff == 2'd2) begin
                     ci_in    = '0;
                     state_in = last_ff ? lbvs_pkg::ST_POS : lbvs_pkg::ST_IDLE;
                  end else begin
                     ci_in = ci_ff + 1'b1;
                  end
               end
            endcase
         end

         // Position times axis scale, one axis at a time.
         lbvs_pkg::ST_POS: begin
            if (st_ff == '0) begin
               mul_a = lbvs_pkg::MUL_W'(lbvs_pkg::sat32(lbvs_pkg::ACC_W'(psum_ff[ci_ff])));
               mul_b = lbvs_pkg::MUL_W'(cur_scale);
               st_in = 4'd1;
            end else begin
               opos_in[ci_ff] = lbvs_pkg::sat32(prod_sh);
               st_in = '0;
               if (ci_ff == 2'd2) begin
                  ci_in    = '0;
                  state_in = lbvs_pkg::ST_NQ;
               end else begin
                  ci_in = ci_ff + 1'b1;
               end
            end
         end

         // Normal divided by the axis scale when normalization is on.
         lbvs_pkg::ST_NQ: begin
            if (norm_ff && (cur_scale != 32'sd0)) begin
               div_start    = 1'b1;
               div_dividend = lbvs_pkg::DVD_W'(lbvs_pkg::abs33(nq)) << FRAC_BITS;
               div_divisor  = lbvs_pkg::DVS_W'(lbvs_pkg::abs33(cur_scale));
               div_neg_in   = nq[31] ^ cur_scale[31];
               state_in     = lbvs_pkg::ST_NQ_WAIT;
            end else begin
               if (!norm_ff) begin
                  q_in[ci_ff] = nq;
               end else if (nq > 32'sd0) begin
                  q_in[ci_ff] = 32'sh7FFF_FFFF;
               end else if (nq < 32'sd0) begin
                  q_in[ci_ff] = 32'sh8000_0000;
               end else begin
                  q_in[ci_ff] = 32'sd0;
               end
               if (ci_ff == 2'd2) begin
                  ci_in    = '0;
                  st_in    = '0;
                  state_in = norm_ff ? lbvs_pkg::ST_SS : lbvs_pkg::ST_EMIT;
               end else begin
                  ci_in = ci_ff + 1'b1;
               end
            end
         end

         lbvs_pkg::ST_NQ_WAIT: begin
            if (div_done) begin
               q_in[ci_ff] = lbvs_pkg::sat_quot(div_neg_ff, div_quot);
               if (ci_ff == 2'd2) begin
                  ci_in    = '0;
                  st_in    = '0;
                  state_in = lbvs_pkg::ST_SS;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  state_in = lbvs_pkg::ST_NQ;
               end
            end
         end

         // Sum of squares of the three quotients.
         lbvs_pkg::ST_SS: begin
            if (st_ff < 4'd3) begin
               mul_a = lbvs_pkg::MUL_W'(q_ff[st_ff[1:0]]);
               mul_b = lbvs_pkg::MUL_W'(q_ff[st_ff[1:0]]);
            end
            if (st_ff == '0) begin
               ss_in = '0;
            end else begin
               ss_in = ss_ff + lbvs_pkg::RAD_W'(prod_ff);
            end
            st_in = st_ff + 1'b1;
            if (st_ff == 4'd3) begin
               st_in    = '0;
               state_in = lbvs_pkg::ST_SQRT;
            end
         end

         lbvs_pkg::ST_SQRT: begin
            if (st_ff == '0) begin
               sqrt_start = 1'b1;
               st_in      = 4'd1;
            end else if (sqrt_done) begin
               len_in   = sqrt_root;
               ci_in    = '0;
               st_in    = '0;
               state_in = lbvs_pkg::ST_ND;
            end
         end

         // Each quotient divided by the length.
         lbvs_pkg::ST_ND: begin
            if (len_ff == '0) begin
               q_in[ci_ff] = 32'sd0;
               if (ci_ff == 2'd2) begin
                  ci_in    = '0;
                  state_in = lbvs_pkg::ST_EMIT;
               end else begin
                  ci_in = ci_ff + 1'b1;
               end
            end else begin
               div_start    = 1'b1;
               div_dividend = lbvs_pkg::DVD_W'(lbvs_pkg::abs33(cur_q)) << FRAC_BITS;
               div_divisor  = len_ff;
               div_neg_in   = cur_q[31];
               state_in     = lbvs_pkg::ST_ND_WAIT;
            end
         end

         lbvs_pkg::ST_ND_WAIT: begin
            if (div_done) begin
               q_in[ci_ff] = lbvs_pkg::sat_quot(div_neg_ff, div_quot);
               if (ci_ff == 2'd2) begin
                  ci_in    = '0;
                  state_in = lbvs_pkg::ST_EMIT;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  state_in = lbvs_pkg::ST_ND;
               end
            end
         end

         // Hand the result to the output register once it is free.
         lbvs_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               for (int k = 0; k < 3; k++) begin
                  psum_in[k] = '0;
                  nsum_in[k] = '0;
               end
               state_in = lbvs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lbvs_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbvs_pkg::ST_IDLE;
         st_ff        <= '0;
         ci_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            psum_ff[k] <= '0;
            nsum_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         ci_ff        <= ci_in;
         rsp_valid_ff <= rsp_valid_in;
         psum_ff      <= psum_in;
         nsum_ff      <= nsum_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bone_ff    <= bone_in;
      bone_ok_ff <= bone_ok_in;
      last_ff    <= last_in;
      pos_ff     <= pos_in;
      nrm_ff     <= nrm_in;
      wt_ff      <= wt_in;
      r_ff       <= r_in;
      v_ff       <= v_in;
      m_ff       <= m_in;
      opos_ff    <= opos_in;
      q_ff       <= q_in;
      ss_ff      <= ss_in;
      len_ff     <= len_in;
      div_neg_ff <= div_neg_in;
      if (rsp_load) begin
         rsp_data_ff <= {q_in[2], q_in[1], q_in[0], opos_ff[2], opos_ff[1], opos_ff[0]};
      end
   end

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            scale_ff[k] <= 32'sd1 <<< FRAC_BITS;
         end
         norm_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (lbvs_pkg::csr_index_type'(csr_index))
            lbvs_pkg::CSR_SCALE_X:   scale_ff[0] <= $signed(csr_data);
            lbvs_pkg::CSR_SCALE_Y:   scale_ff[1] <= $signed(csr_data);
            lbvs_pkg::CSR_SCALE_Z:   scale_ff[2] <= $signed(csr_data);
            lbvs_pkg::CSR_NORMALIZE: norm_ff     <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_div_done_waits: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lbvs_pkg::ST_NQ_WAIT || state_ff == lbvs_pkg::ST_ND_WAIT))
      else $error("divider finished outside a wait state");

   a_sqrt_done_waits: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == lbvs_pkg::ST_SQRT))
      else $error("square root finished outside its wait state");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_load) |=> (rsp_tvalid && psum_ff[0] == '0 && psum_ff[2] == '0 &&
                                nsum_ff[0] == '0 && nsum_ff[2] == '0))
      else $error("sums not cleared after a result");
`endif

endmodule

`default_nettype wire

// ----- src/lbvs_ram.sv -----
`default_nettype none

module lbvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 768
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/lbvs_div.sv -----
`default_nettype none

module lbvs_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [lbvs_pkg::DVD_W-1:0] dividend,
   input  wire logic [lbvs_pkg::DVS_W-1:0] divisor,
   output logic                          done,
   output logic      [lbvs_pkg::DVD_W-1:0] quotient
);

   localparam int CW = $clog2(lbvs_pkg::DVD_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [lbvs_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [lbvs_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [lbvs_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [lbvs_pkg::DVS_W:0]     rem_sh;
   logic [lbvs_pkg::DVS_W:0]     diff;
   logic                         ge;

   // Restoring division, one quotient bit per cycle, magnitudes only.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[lbvs_pkg::DVD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(lbvs_pkg::DVD_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[lbvs_pkg::DVS_W-1:0] : rem_sh[lbvs_pkg::DVS_W-1:0];
         quo_in = {quo_ff[lbvs_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/lbvs_sqrt.sv -----
`default_nettype none

module lbvs_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [lbvs_pkg::RAD_W-1:0]  radicand,
   output logic                           done,
   output logic      [lbvs_pkg::ROOT_W-1:0] root
);

   localparam int W = lbvs_pkg::RAD_W;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] x_ff, x_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] bit_ff, bit_in;
   logic [W-1:0] trial;

   // Digit-by-digit integer square root, two radicand bits per cycle.
   always_comb begin
      trial   = r_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         r_in    = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[lbvs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
   import lbvs_pkg::*;

   localparam int FB = FRAC_BITS_DEFAULT;
   localparam int NBONES = MAX_BONES_DEFAULT;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
   localparam longint MIN32 = -64'sh0000_0000_8000_0000;
   localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint MIN48 = -64'sh0000_8000_0000_0000;
   localparam int RANDOM_ITEMS = 850;
   localparam int PHASE_ITEMS = 150;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [BONE_W-1:0]   bone;
      logic [WIDX_W-1:0]   widx;
      logic signed [31:0]  wval;
      logic signed [31:0]  pos [3];
      logic signed [17:0]  nrm [3];
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } skin_req;

   typedef struct {
      logic [31:0] f [6];
   } skin_rsp;

   typedef struct {
      skin_req item;
      bit      typed;
      skin_rsp rsp;
   } stim_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Predictor copy of the block state and configuration.
   int     bone_words [NBONES*WORDS_PER_BONE];
   longint pos_acc [3];
   longint nrm_acc [3];
   longint axis_scale [3];
   bit     renorm;

   skin_rsp vertex_q [$];
   int errors = 0;
   int burst_left = 0;
   bit long_hold_req = 0;
   stim_row rows [$];

   linear_blend_vertex_skinning_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic longint sat(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scale the position, divide and renormalize the normal when enabled, then clear the sums.
   function automatic skin_rsp finish_vertex();
      skin_rsp o;
      longint q [3];
      longint pc, n;
      longint unsigned ss = 0, len;
      for (int i = 0; i < 3; i++) begin
         pc = sat(pos_acc[i], MIN32, MAX32);
         o.f[i] = 32'(sat((pc * axis_scale[i]) >>> FB, MIN32, MAX32));
      end
      for (int i = 0; i < 3; i++) begin
         n = sat(nrm_acc[i], MIN32, MAX32);
         if (!renorm) q[i] = n;
         else if (axis_scale[i] == 0) q[i] = n > 0 ? MAX32 : (n < 0 ? MIN32 : 0);
         else q[i] = sat((n * (64'sd1 <<< FB)) / axis_scale[i], MIN32, MAX32);
      end
      if (renorm) begin
         for (int i = 0; i < 3; i++) ss += longint'(q[i] * q[i]);
         len = int_sqrt(ss);
         for (int i = 0; i < 3; i++)
            q[i] = (len == 0) ? 0 : sat((q[i] * (64'sd1 <<< FB)) / longint'(len), MIN32, MAX32);
      end
      for (int i = 0; i < 3; i++) o.f[3+i] = 32'(q[i]);
      for (int i = 0; i < 3; i++) begin
         pos_acc[i] = 0;
         nrm_acc[i] = 0;
      end
      return o;
   endfunction

   // Advance the predictor by one accepted beat; returns 1 when a result follows.
   function automatic bit skin_predict(skin_req it, output skin_rsp o);
      longint v, m, r, w;
      o = '{f: '{default: 0}};
      w = longint'(it.weight);
      case (it.op)
         OP_LOAD: begin
            if (it.widx < WORDS_PER_BONE)
               bone_words[it.bone*WORDS_PER_BONE + it.widx] = it.wval;
            return 0;
         end
         OP_UNSKINNED: begin
            for (int i = 0; i < 3; i++) begin
               pos_acc[i] = longint'(it.pos[i]);
               nrm_acc[i] = longint'(it.nrm[i]);
            end
            o = finish_vertex();
            return 1;
         end
         OP_INFLUENCE: begin
            for (int i = 0; i < 3; i++) begin
               v = longint'(bone_words[it.bone*WORDS_PER_BONE + TRANS_BASE + i]);
               m = 0;
               for (int j = 0; j < 3; j++) begin
                  r = longint'(bone_words[it.bone*WORDS_PER_BONE + 3*i + j]);
                  v += (r * longint'(it.pos[j])) >>> FB;
                  m += (r * longint'(it.nrm[j])) >>> FB;
               end
               v = sat(v, MIN32, MAX32);
               m = sat(m, MIN32, MAX32);
               pos_acc[i] = sat(pos_acc[i] + ((v * w) >>> FB), MIN48, MAX48);
               nrm_acc[i] = sat(nrm_acc[i] + ((m * w) >>> FB), MIN48, MAX48);
            end
            if (!it.last) return 0;
            o = finish_vertex();
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Drive one request beat and wait until it is taken; bursts with random gaps.
   task automatic send_req(skin_req it, bit typed = 0, skin_rsp typed_rsp = '{f: '{default: 0}});
      skin_rsp o;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tlast <= it.last;
      req_tdata <= {7'b0, it.weight, it.nrm[2], it.nrm[1], it.nrm[0],
                    it.pos[2], it.pos[1], it.pos[0], it.wval, it.widx, it.bone};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (skin_predict(it, o)) vertex_q.push_back(typed ? typed_rsp : o);
   endtask

   // Stop sending, wait for every result, then let the pipeline settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NORMALIZE) renorm = value[0];
      else axis_scale[idx] = longint'($signed(value));
   endtask

   task automatic apply_setting(int k);
      logic [31:0] s [3];
      logic [31:0] en;
      case (k % 6)
         0: begin s = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}; en = 1; end
         1: begin s = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}; en = 1; end
         2: begin s = '{$urandom, $urandom, $urandom}; en = 0; end
         3: begin s = '{32'h0, 32'h0, 32'h0}; en = 32'hFFFF_FFFF; end
         4: begin s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000}; en = 32'hFFFF_FFFE; end
         default: begin
            s = '{32'($urandom_range(0, 1 << 19)) - 32'h4_0000,
                  32'($urandom_range(0, 1 << 19)) - 32'h4_0000,
                  32'($urandom_range(0, 1 << 19)) - 32'h4_0000};
            en = 1;
         end
      endcase
      write_csr(CSR_SCALE_X, s[0]);
      write_csr(CSR_SCALE_Y, s[1]);
      write_csr(CSR_SCALE_Z, s[2]);
      write_csr(CSR_NORMALIZE, en);
      csr_valid <= 1'b0;
   endtask

   function automatic skin_req blank_req(logic [OP_W-1:0] op);
      skin_req it;
      it.op = op;
      it.bone = '0;
      it.widx = '0;
      it.wval = '0;
      it.pos = '{default: 0};
      it.nrm = '{default: 0};
      it.weight = '0;
      it.last = 1'b0;
      return it;
   endfunction

   function automatic skin_req rand_vertex_fields(skin_req it);
      for (int i = 0; i < 3; i++) begin
         it.pos[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                     : 32'($urandom_range(0, 1 << 22)) - 32'h20_0000;
         it.nrm[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
      end
      return it;
   endfunction

   function automatic skin_req rand_influence(bit last);
      skin_req it;
      it = rand_vertex_fields(blank_req(OP_INFLUENCE));
      it.bone = 6'($urandom);
      it.wval = $urandom;
      it.widx = 4'($urandom);
      case ($urandom_range(0, 7))
         0: it.weight = 17'd65536;
         1: it.weight = 17'd0;
         default: it.weight = 17'($urandom_range(0, 65536));
      endcase
      it.last = last;
      return it;
   endfunction

   // Receiver readiness: its own pattern, plus one long hold-off on request.
   initial begin
      int hold = 0;
      int mode = 0;
      int cyc = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            hold = 3000;
            long_hold_req = 0;
         end
         if (cyc % 50 == 0) mode = $urandom_range(0, 2);
         cyc++;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      skin_rsp want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (vertex_q.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_tdata[31:0], 32'h0);
         end else begin
            want = vertex_q.pop_front();
            for (int i = 0; i < 6; i++)
               if (rsp_tdata[32*i +: 32] !== want.f[i])
                  report_mismatch(i < 3 ? $sformatf("out_pos[%0d]", i)
                                        : $sformatf("out_nrm[%0d]", i - 3),
                                  rsp_tdata[32*i +: 32], want.f[i]);
         end
      end
   end

   initial begin
      skin_req it;
      stim_row row;
      int count, phase, ninf;

      for (int i = 0; i < NBONES*WORDS_PER_BONE; i++) bone_words[i] = 0;
      for (int i = 0; i < 3; i++) begin
         pos_acc[i] = 0;
         nrm_acc[i] = 0;
         axis_scale[i] = 64'sd1 <<< FB;
      end
      renorm = 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole bone table: tame rotations for most bones, raw words for the rest.
      for (int b = 0; b < NBONES; b++)
         for (int w = 0; w < WORDS_PER_BONE; w++) begin
            it = blank_req(OP_LOAD);
            it.bone = 6'(b);
            it.widx = 4'(w);
            if (b >= 48) it.wval = $urandom;
            else if (w < TRANS_BASE) it.wval = $signed($urandom_range(0, 131072)) - 65536;
            else it.wval = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            send_req(it);
         end

      // Directed rows under the reset configuration.
      row.typed = 1;
      row.item = blank_req(OP_UNSKINNED);
      row.item.pos = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0};
      row.item.nrm = '{18'sd65536, 18'sd0, 18'sd0};
      row.rsp.f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
      rows.push_back(row);
      row.item = blank_req(OP_UNSKINNED);
      row.item.pos = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000};
      row.item.nrm = '{18'sd0, 18'sd0, -18'sd65536};
      row.rsp.f = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_0000};
      rows.push_back(row);
      // Zero-length normal gives a zero normal.
      row.item = blank_req(OP_UNSKINNED);
      row.item.pos = '{32'sh1234_5678, -32'sh1, 32'sh1};
      row.rsp.f = '{32'h1234_5678, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h0};
      rows.push_back(row);
      // A zero-weight influence contributes nothing.
      row.item = rand_influence(1);
      row.item.weight = 17'd0;
      row.rsp.f = '{default: 32'h0};
      rows.push_back(row);
      row.typed = 0;
      // Loads past word eleven and the spare op leave the state alone.
      for (int w = 12; w < 16; w++) begin
         row.item = blank_req(OP_LOAD);
         row.item.bone = 6'd63;
         row.item.widx = 4'(w);
         row.item.wval = 32'hFFFF_FFFF;
         rows.push_back(row);
      end
      row.item = rand_influence(0);
      row.item.op = OP_SPARE;
      row.item.last = 1'b1;
      rows.push_back(row);
      // Full weight influences on the edge bones, in pairs that each form one vertex.
      for (int k = 0; k < 4; k++) begin
         row.item = rand_influence(k % 2);
         row.item.bone = (k < 2) ? 6'd0 : 6'd63;
         row.item.weight = 17'd65536;
         if (k == 3) row.item.pos = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
         rows.push_back(row);
      end
      // Pending sums are dropped by an unskinned vertex.
      row.item = rand_influence(0);
      rows.push_back(row);
      row.item = rand_vertex_fields(blank_req(OP_UNSKINNED));
      rows.push_back(row);
      // Reload a word, then use that bone.
      row.item = blank_req(OP_LOAD);
      row.item.bone = 6'd5;
      row.item.widx = 4'd4;
      row.item.wval = 32'sh8000_0000;
      rows.push_back(row);
      row.item = rand_influence(1);
      row.item.bone = 6'd5;
      rows.push_back(row);
      foreach (rows[i]) send_req(rows[i].item, rows[i].typed, rows[i].rsp);
      drain_results();

      // Random vertices, reloads and noise across several configurations.
      count = 0;
      phase = 1;
      apply_setting(phase);
      while (count < RANDOM_ITEMS) begin
         if (count >= PHASE_ITEMS * phase) begin
            drain_results();
            phase++;
            apply_setting(phase);
         end
         if (count >= 700 && count < 705) long_hold_req = 1;
         case ($urandom_range(0, 19))
            0, 1: begin
               it = blank_req(OP_LOAD);
               it.bone = 6'($urandom);
               it.widx = 4'($urandom_range(0, 15));
               it.wval = ($urandom_range(0, 1) == 0) ? 32'($urandom)
                         : $signed($urandom_range(0, 131072)) - 65536;
               it.last = 1'($urandom);
               send_req(it);
               count++;
            end
            2: begin
               send_req(rand_vertex_fields(blank_req(OP_UNSKINNED)));
               count++;
            end
            3: begin
               it = rand_influence(1'($urandom));
               it.op = OP_SPARE;
               send_req(it);
            end
            default: begin
               ninf = $urandom_range(1, 4);
               for (int k = 0; k < ninf; k++) begin
                  send_req(rand_influence(k == ninf - 1));
                  count++;
               end
            end
         endcase
      end
      drain_results();

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
